### design/deq_pkg.sv
package deq_pkg;

    // default sizing
    localparam int DEPTH_DEF      = 4096;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths
    localparam int OP_W     = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    // command codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_SIZE       = 3'd4;
    localparam logic [OP_W-1:0] OP_EMPTY      = 3'd5;
    localparam logic [OP_W-1:0] OP_FRONT      = 3'd6;
    localparam logic [OP_W-1:0] OP_BACK       = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // command word
    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [WORD_W-1:0] push_value;
    } deq_cmd_t;

    // response word
    typedef struct packed {
        logic [WORD_W-1:0]   result_data;
        logic [STATUS_W-1:0] status;
    } deq_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic exec;
        logic emit;
    } deq_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic rsp_free;
    } deq_stat_t;

endpackage

### design/double_ended_queue_unit.sv
// channel   direction  handshake              word
// cmd       in         cmd_valid / cmd_ready  opcode, push_value
// rsp       out        rsp_valid / rsp_ready  result_data, status
//
// one command passes through capture, store access and response load
// the entry store is single-port with a registered read
// a new command is taken while the previous response waits in its register
// a stalled response holds the sequencer before the load, never the store
// after reset the deque is empty; store contents are unknown until pushed
module double_ended_queue_unit #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  deq_pkg::deq_cmd_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output deq_pkg::deq_rsp_t rsp
);
    import deq_pkg::*;

    deq_ctrl_t ctrl;
    deq_stat_t stat;

    // sequencer
    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    // store, pointers and response register
    deq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .ctrl      (ctrl),
        .stat      (stat)
    );

endmodule

### design/deq_dp.sv
module deq_dp #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  deq_pkg::deq_cmd_t  cmd,
    output deq_pkg::deq_rsp_t  rsp,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  deq_pkg::deq_ctrl_t ctrl,
    output deq_pkg::deq_stat_t stat
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [WORD_W-1:0] NONE_WORD = WORD_W'({DATA_WIDTH{1'b1}});

    // ring pointer steps
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [OP_W-1:0]       op_reg;
    logic [WORD_W-1:0]     val_reg;
    logic [AW-1:0]         head_reg, head_next;
    logic [AW-1:0]         tail_reg, tail_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] rd_word_reg;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  res_use_mem_reg, res_use_mem_next;
    logic [WORD_W-1:0]     res_imm_reg, res_imm_next;
    deq_rsp_t              rsp_reg;
    logic                  rsp_valid_reg;
    logic [AW-1:0]         addr;
    logic                  we;
    logic                  full;
    logic                  empty;

    // captured command, payload only
    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            op_reg  <= cmd.opcode;
            val_reg <= cmd.push_value;
        end
    end

    // operation decode and pointer update
    always_comb
    begin
        full             = (cnt_reg == CW'(DEPTH));
        empty            = (cnt_reg == '0);
        head_next        = head_reg;
        tail_next        = tail_reg;
        cnt_next         = cnt_reg;
        addr             = head_reg;
        we               = 1'b0;
        res_status_next  = ST_OK;
        res_use_mem_next = 1'b0;
        res_imm_next     = '0;
        case (op_reg)
            OP_PUSH_FRONT:
            begin
                addr = ptr_dec(head_reg);
                if (full)
                    res_status_next = ST_FULL;
                else
                begin
                    we        = ctrl.exec;
                    head_next = addr;
                    cnt_next  = cnt_reg + CW'(1);
                end
            end
            OP_PUSH_BACK:
            begin
                addr = tail_reg;
                if (full)
                    res_status_next = ST_FULL;
                else
                begin
                    we        = ctrl.exec;
                    tail_next = ptr_inc(tail_reg);
                    cnt_next  = cnt_reg + CW'(1);
                end
            end
            OP_POP_FRONT:
            begin
                addr = head_reg;
                if (empty)
                begin
                    res_status_next = ST_EMPTY;
                    res_imm_next    = NONE_WORD;
                end
                else
                begin
                    res_use_mem_next = 1'b1;
                    head_next        = ptr_inc(head_reg);
                    cnt_next         = cnt_reg - CW'(1);
                end
            end
            OP_POP_BACK:
            begin
                addr = ptr_dec(tail_reg);
                if (empty)
                begin
                    res_status_next = ST_EMPTY;
                    res_imm_next    = NONE_WORD;
                end
                else
                begin
                    res_use_mem_next = 1'b1;
                    tail_next        = addr;
                    cnt_next         = cnt_reg - CW'(1);
                end
            end
            OP_SIZE:
                res_imm_next = WORD_W'(cnt_reg);
            OP_EMPTY:
                res_imm_next = WORD_W'(empty);
            OP_FRONT:
            begin
                addr = head_reg;
                if (empty)
                begin
                    res_status_next = ST_EMPTY;
                    res_imm_next    = NONE_WORD;
                end
                else
                    res_use_mem_next = 1'b1;
            end
            default:
            begin
                addr = ptr_dec(tail_reg);
                if (empty)
                begin
                    res_status_next = ST_EMPTY;
                    res_imm_next    = NONE_WORD;
                end
                else
                    res_use_mem_next = 1'b1;
            end
        endcase
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (ctrl.exec)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    // entry store, one port, registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            if (we)
                mem[addr] <= DATA_WIDTH'(val_reg);
            rd_word_reg <= mem[addr];
        end
    end

    // result fields held until the response slot frees
    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            res_status_reg  <= res_status_next;
            res_use_mem_reg <= res_use_mem_next;
            res_imm_reg     <= res_imm_next;
        end
        if (ctrl.emit)
        begin
            rsp_reg.result_data <= res_use_mem_reg ? WORD_W'(rd_word_reg) : res_imm_reg;
            rsp_reg.status      <= res_status_reg;
        end
    end

    // response valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (ctrl.emit)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    assign rsp           = rsp_reg;
    assign rsp_valid     = rsp_valid_reg;
    assign stat.rsp_free = !rsp_valid_reg || rsp_ready;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> (!rsp_valid_reg || rsp_ready))
        else $error("response overwritten before taken");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exec && (op_reg == OP_PUSH_BACK || op_reg == OP_PUSH_FRONT) && !full
        |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("push did not grow occupancy");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exec && (op_reg == OP_POP_FRONT || op_reg == OP_POP_BACK) && empty
        |=> res_status_reg == ST_EMPTY && cnt_reg == '0)
        else $error("pop on empty deque not flagged");

endmodule

### design/deq_ctrl.sv
module deq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    output deq_pkg::deq_ctrl_t ctrl,
    input  deq_pkg::deq_stat_t stat
);
    import deq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        cmd_ready  = 1'b0;
        ctrl       = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctrl.take  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctrl.exec  = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.rsp_free)
                begin
                    ctrl.emit  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
